// File: design/wfrv_pkg.sv
package wfrv_pkg;

	localparam int WORD_W = 16;
	localparam int COUNT_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_FRAME_WORDS_DEF = 30;

	localparam logic [WORD_W-1:0] SYNC_WORD_A = 16'hAAAA;
	localparam logic [WORD_W-1:0] SYNC_WORD_B = 16'h5555;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_CHECKSUM   = 3'd1,
		ST_SEQUENCE   = 3'd2,
		ST_HEADER     = 3'd3,
		ST_TYPE       = 3'd4,
		ST_PAYLOAD    = 3'd5,
		ST_OVERLENGTH = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACK_CODE    = 3'd0,
		CFG_STATUS_CODE = 3'd1,
		CFG_ERROR_CODE  = 3'd2,
		CFG_PARAM_CODE  = 3'd3,
		CFG_ACK_WORD    = 3'd4,
		CFG_PARAM_COUNT = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} in_t;

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   response_code;
		logic [WORD_W-1:0]   first_payload;
		logic [2*WORD_W-1:0] param_value;
		logic [WORD_W-1:0]   frame_sequence;
	} out_t;

	typedef struct packed {
		logic [WORD_W-1:0] resp_ack_code;
		logic [WORD_W-1:0] resp_status_code;
		logic [WORD_W-1:0] resp_error_code;
		logic [WORD_W-1:0] resp_param_code;
		logic [WORD_W-1:0] ack_word;
		logic [WORD_W-1:0] param_index_count;
	} cfg_t;

endpackage

// File: design/wfrv_cfg_regs.sv
module wfrv_cfg_regs
	import wfrv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [WORD_W-1:0]    wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_ack_code     <= 16'd8;
			cfg_q.resp_status_code  <= 16'd9;
			cfg_q.resp_error_code   <= 16'd10;
			cfg_q.resp_param_code   <= 16'd11;
			cfg_q.ack_word          <= 16'd0;
			cfg_q.param_index_count <= 16'd32;
		end else if (wr_en) begin
			// indexes past the register list are dropped
			unique case (cfg_idx_t'(wr_index))
				CFG_ACK_CODE:    cfg_q.resp_ack_code     <= wr_data;
				CFG_STATUS_CODE: cfg_q.resp_status_code  <= wr_data;
				CFG_ERROR_CODE:  cfg_q.resp_error_code   <= wr_data;
				CFG_PARAM_CODE:  cfg_q.resp_param_code   <= wr_data;
				CFG_ACK_WORD:    cfg_q.ack_word          <= wr_data;
				CFG_PARAM_COUNT: cfg_q.param_index_count <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/wfrv_frame_check.sv
module wfrv_frame_check
	import wfrv_pkg::*;
#(
	parameter int MAX_FRAME_WORDS = MAX_FRAME_WORDS_DEF
)
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic word_en,
	input  in_t  word_s1,
	output out_t result
);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] MAX_WORDS = COUNT_W'(MAX_FRAME_WORDS);

	logic [COUNT_W-1:0]  count_q;
	logic [WORD_W-1:0]   sum_q;
	logic [WORD_W-1:0]   exp_seq_q;
	logic                hdr_q;
	logic [WORD_W-1:0]   seq_q;
	logic [WORD_W-1:0]   code_q;
	logic [WORD_W-1:0]   pay_q;
	logic [2*WORD_W-1:0] val_q;

	logic                hdr;
	logic                hdr_final;
	logic [WORD_W-1:0]   seq;
	logic [WORD_W-1:0]   code;
	logic [WORD_W-1:0]   pay;
	logic [2*WORD_W-1:0] val;
	status_t             status;
	logic [WORD_W-1:0]   w;

	assign w = word_s1.word;

	// place the word at its frame position, the closing word included
	always_comb begin
		hdr  = hdr_q;
		seq  = seq_q;
		code = code_q;
		pay  = pay_q;
		val  = val_q;
		unique case (count_q)
			6'd0: hdr = (w == SYNC_WORD_A);
			6'd1: hdr = hdr_q && (w == SYNC_WORD_B);
			6'd3: seq = w;
			6'd4: code = w;
			6'd5: pay = w;
			6'd6: val[WORD_W-1:0] = w;
			6'd7: val[2*WORD_W-1:WORD_W] = w;
			default: ;
		endcase
	end

	// a frame closing at position 0 never saw its second sync word
	assign hdr_final = hdr && (count_q != '0);

	always_comb begin
		priority if (count_q >= MAX_WORDS)
			status = ST_OVERLENGTH;
		else if (w != sum_q)
			status = ST_CHECKSUM;
		else if (seq != exp_seq_q)
			status = ST_SEQUENCE;
		else if (!hdr_final)
			status = ST_HEADER;
		else if (code == cfg.resp_ack_code)
			status = (pay != cfg.ack_word) ? ST_PAYLOAD : ST_OK;
		else if (code == cfg.resp_status_code || code == cfg.resp_error_code)
			status = ST_OK;
		else if (code == cfg.resp_param_code)
			status = (pay >= cfg.param_index_count) ? ST_PAYLOAD : ST_OK;
		else
			status = ST_TYPE;
	end

	always_comb begin
		result.status         = status;
		result.response_code  = code;
		result.first_payload  = pay;
		result.param_value    = val;
		result.frame_sequence = exp_seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_q     <= '0;
			exp_seq_q <= WORD_W'(1);
			hdr_q     <= 1'b0;
			seq_q     <= '0;
			code_q    <= '0;
			pay_q     <= '0;
			val_q     <= '0;
		end else if (word_en) begin
			if (word_s1.last) begin
				count_q <= '0;
				sum_q   <= '0;
				hdr_q   <= 1'b0;
				seq_q   <= '0;
				code_q  <= '0;
				pay_q   <= '0;
				val_q   <= '0;
				if (status == ST_OK)
					exp_seq_q <= exp_seq_q + WORD_W'(1);
			end else begin
				hdr_q  <= hdr;
				seq_q  <= seq;
				code_q <= code;
				pay_q  <= pay;
				val_q  <= val;
				sum_q  <= sum_q + w;
				if (count_q != COUNT_MAX)
					count_q <= count_q + COUNT_W'(1);
			end
		end
	end

endmodule

// File: design/word_frame_response_validator.sv
// Checks response frames that arrive one 16-bit word per transfer, the last word flagged and
// carrying the modulo-65536 sum of the earlier words. Words are taken at one per cycle, with no
// gaps needed, while the input is not stalled; each word passes an input register and then the
// capture and compare logic, and a frame's verdict is registered at the output when its last
// word leaves the input register. Only one result is produced per frame, at the last word. The
// input stalls only while a last word waits behind a result that has not been taken yet. The
// verdict reports the first failing check in the order overlength, checksum, sequence, header,
// response type, payload; the expected sequence number starts at 1 and steps only on an ok
// verdict. Configuration writes are always ready and must be made while no frame is in flight.
module word_frame_response_validator
	import wfrv_pkg::*;
#(
	parameter int MAX_FRAME_WORDS = MAX_FRAME_WORDS_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	cfg_t cfg;
	logic valid_s1;
	in_t  data_s1;
	logic adv_s1;
	out_t result;
	logic out_valid_q;
	out_t out_data_q;

	assign cfg_ready = 1'b1;

	wfrv_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// a last word moves on only if the result slot is free or being emptied
	assign adv_s1   = valid_s1 && (!data_s1.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s1 <= in_data;
	end

	wfrv_frame_check #(
		.MAX_FRAME_WORDS (MAX_FRAME_WORDS)
	) u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.word_en (adv_s1),
		.word_s1 (data_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1 && data_s1.last)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && data_s1.last)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: design/wfrv_checker.sv
module wfrv_checker
	import wfrv_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_t  in_data,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// status stays within its defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 3'd7)
		else $error("undefined status code");

	// input backpressure only comes from a blocked result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with result path free");

	// a result appears only after a last word was taken
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_data.last, 2))
		else $error("result without a closing word");

endmodule

bind word_frame_response_validator wfrv_checker u_wfrv_checker (.*);

// File: tb/word_frame_response_validator_test.sv
`timescale 1ns / 1ps

module word_frame_response_validator_test;
	import wfrv_pkg::*;

	localparam int MAX_WORDS = MAX_FRAME_WORDS_DEF;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_BURSTY
	} sink_mode_t;

	typedef enum int {
		K_ACK_OK,
		K_ACK_NAK,
		K_STATUS,
		K_ERROR,
		K_PARAM_OK,
		K_PARAM_BAD,
		K_FOREIGN
	} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	word_frame_response_validator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("word_frame_response_validator_test: FAIL");
		$finish;
	end

	// frame tracker state, mirrors the block
	cfg_t        cfg_model = '{16'd8, 16'd9, 16'd10, 16'd11, 16'd0, 16'd32};
	logic [5:0]  pos_count = '0;
	logic [15:0] word_sum = '0;
	logic [15:0] next_seq = 16'd1;
	logic        sync_ok = 1'b0;
	logic [15:0] cap_seq = '0;
	logic [15:0] cap_code = '0;
	logic [15:0] cap_payload = '0;
	logic [31:0] cap_value = '0;

	out_t        pending_verdicts[$];
	logic [15:0] frame_words[$];

	int unsigned fail_count = 0;
	int unsigned words_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned status_hits[0:7];

	sink_mode_t  sink_mode = SINK_OPEN;
	int unsigned hold_cnt = 0;
	int unsigned burst_left = 0;
	int unsigned src_gap_max = 0;

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	function automatic void track_word(input logic [15:0] w, input logic lst);
		logic [5:0]  pos;
		logic        sync;
		logic [15:0] seq;
		logic [15:0] code;
		logic [15:0] pay;
		logic [31:0] val;
		out_t        v;
		pos = pos_count;
		sync = sync_ok;
		seq = cap_seq;
		code = cap_code;
		pay = cap_payload;
		val = cap_value;
		case (pos)
			6'd0: sync = (w == SYNC_WORD_A);
			6'd1: sync = sync && (w == SYNC_WORD_B);
			6'd3: seq = w;
			6'd4: code = w;
			6'd5: pay = w;
			6'd6: val[15:0] = w;
			6'd7: val[31:16] = w;
			default: ;
		endcase
		if (!lst) begin
			sync_ok = sync;
			cap_seq = seq;
			cap_code = code;
			cap_payload = pay;
			cap_value = val;
			word_sum = word_sum + w;
			if (pos_count != 6'd63)
				pos_count = pos_count + 6'd1;
			return;
		end
		// a one-word frame never saw the second sync word
		if (pos == 6'd0)
			sync = 1'b0;
		if (int'(pos) >= MAX_WORDS)
			v.status = ST_OVERLENGTH;
		else if (w != word_sum)
			v.status = ST_CHECKSUM;
		else if (seq != next_seq)
			v.status = ST_SEQUENCE;
		else if (!sync)
			v.status = ST_HEADER;
		else if (code == cfg_model.resp_ack_code)
			v.status = (pay != cfg_model.ack_word) ? ST_PAYLOAD : ST_OK;
		else if (code == cfg_model.resp_status_code || code == cfg_model.resp_error_code)
			v.status = ST_OK;
		else if (code == cfg_model.resp_param_code)
			v.status = (pay >= cfg_model.param_index_count) ? ST_PAYLOAD : ST_OK;
		else
			v.status = ST_TYPE;
		v.response_code = code;
		v.first_payload = pay;
		v.param_value = val;
		v.frame_sequence = next_seq;
		pending_verdicts.push_back(v);
		frames_sent++;
		if (v.status == ST_OK)
			next_seq = next_seq + 16'd1;
		pos_count = '0;
		word_sum = '0;
		sync_ok = 1'b0;
		cap_seq = '0;
		cap_code = '0;
		cap_payload = '0;
		cap_value = '0;
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else begin
			case (sink_mode)
				SINK_OPEN: out_ready <= 1'b1;
				SINK_COIN: out_ready <= 1'($urandom_range(0, 1));
				default: begin
					out_ready <= !out_ready;
					hold_cnt <= out_ready ? $urandom_range(0, 7) : $urandom_range(0, 12);
				end
			endcase
		end
	end

	// verdict checker
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				note_failure($sformatf("unexpected verdict, status %0d code %h",
					out_data.status, out_data.response_code));
			end else begin
				want = pending_verdicts.pop_front();
				if (out_data.status !== want.status
						|| out_data.response_code !== want.response_code
						|| out_data.first_payload !== want.first_payload
						|| out_data.param_value !== want.param_value
						|| out_data.frame_sequence !== want.frame_sequence) begin
					note_failure($sformatf({"verdict mismatch: expected st %0d code %h pay %h ",
						"val %h seq %h, got st %0d code %h pay %h val %h seq %h"},
						want.status, want.response_code, want.first_payload,
						want.param_value, want.frame_sequence,
						out_data.status, out_data.response_code, out_data.first_payload,
						out_data.param_value, out_data.frame_sequence));
				end else begin
					status_hits[want.status]++;
				end
			end
		end
	end

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: pick_word = 16'h0000;
			1: pick_word = 16'hFFFF;
			default: pick_word = 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] nonzero16();
		nonzero16 = 16'($urandom_range(1, 65535));
	endfunction

	task automatic send_word(input logic [15:0] w, input logic lst);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= '{word: w, last: lst};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		track_word(w, lst);
	endtask

	// sends the queued body words, then the checksum, corrupted when bad_sum is set, as the flagged word
	task automatic send_frame(input logic bad_sum);
		logic [15:0] sum;
		sum = '0;
		foreach (frame_words[i]) begin
			sum = sum + frame_words[i];
			send_word(frame_words[i], 1'b0);
		end
		if (bad_sum)
			sum = sum ^ nonzero16();
		send_word(sum, 1'b1);
	endtask

	task automatic build_frame(input int body_len, input frame_kind_t kind);
		logic [15:0] code;
		logic [15:0] pay;
		logic [31:0] val;
		logic [15:0] w;
		int          i;
		val = {pick_word(), pick_word()};
		pay = pick_word();
		case (kind)
			K_ACK_OK: begin
				code = cfg_model.resp_ack_code;
				pay = cfg_model.ack_word;
			end
			K_ACK_NAK: begin
				code = cfg_model.resp_ack_code;
				pay = cfg_model.ack_word ^ nonzero16();
			end
			K_STATUS: code = cfg_model.resp_status_code;
			K_ERROR: code = cfg_model.resp_error_code;
			K_PARAM_OK: begin
				code = cfg_model.resp_param_code;
				if (cfg_model.param_index_count != 0)
					pay = 16'($urandom_range(0, cfg_model.param_index_count - 1));
			end
			K_PARAM_BAD: begin
				code = cfg_model.resp_param_code;
				pay = 16'($urandom_range(cfg_model.param_index_count, 65535));
			end
			default: code = pick_word();
		endcase
		frame_words.delete();
		for (i = 0; i < body_len; i++) begin
			case (i)
				0: w = SYNC_WORD_A;
				1: w = SYNC_WORD_B;
				3: w = next_seq;
				4: w = code;
				5: w = pay;
				6: w = val[15:0];
				7: w = val[31:16];
				default: w = pick_word();
			endcase
			frame_words.push_back(w);
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_writes++;
	endtask

	task automatic set_config(input cfg_t c);
		write_reg(CFG_ACK_CODE, c.resp_ack_code);
		write_reg(CFG_STATUS_CODE, c.resp_status_code);
		write_reg(CFG_ERROR_CODE, c.resp_error_code);
		write_reg(CFG_PARAM_CODE, c.resp_param_code);
		write_reg(CFG_ACK_WORD, c.ack_word);
		write_reg(CFG_PARAM_COUNT, c.param_index_count);
		cfg_valid <= 1'b0;
		cfg_model = c;
	endtask

	// lets every verdict drain, plus the pipeline depth, before touching registers
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic pick_pacing();
		if ($urandom_range(0, 5) == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 2));
			src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
		end
	endtask

	task automatic test_directed_frames();
		sink_mode <= SINK_COIN;
		src_gap_max = 2;
		// lone zero word: checksum holds, sequence does not
		send_word(16'h0000, 1'b1);
		// acknowledge at reset settings
		frame_words = '{SYNC_WORD_A, SYNC_WORD_B, 16'hFFFF, next_seq, 16'd8, 16'd0};
		send_frame(1'b0);
		// status response with no payload check
		frame_words = '{SYNC_WORD_A, SYNC_WORD_B, 16'h0000, next_seq, 16'd9, 16'h1234};
		send_frame(1'b0);
		// parameter index all ones, past the index count, and an all-ones value
		frame_words = '{SYNC_WORD_A, SYNC_WORD_B, 16'h0000, next_seq, 16'd11,
			16'hFFFF, 16'hFFFF, 16'hFFFF};
		send_frame(1'b0);
		// short frame: checksum lands in the sequence slot and matches it
		frame_words = '{SYNC_WORD_A, SYNC_WORD_B, next_seq + 16'd1};
		send_frame(1'b0);
		wait_idle();
	endtask

	task automatic test_random_frames();
		cfg_t        c;
		int unsigned target;
		int unsigned roll;
		int          phase;
		int          n;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: ;
				1: begin
					c = {6{16'h0}};
					c.resp_ack_code = pick_word();
					c.resp_status_code = pick_word();
					c.resp_error_code = pick_word();
					c.resp_param_code = pick_word();
					c.ack_word = pick_word();
					c.param_index_count = pick_word();
					set_config(c);
				end
				2: set_config({6{16'h0000}});
				3: set_config({6{16'hFFFF}});
				default: begin
					// narrow code space, so codes often collide
					c.resp_ack_code = 16'($urandom_range(0, 7));
					c.resp_status_code = 16'($urandom_range(0, 7));
					c.resp_error_code = 16'($urandom_range(0, 7));
					c.resp_param_code = 16'($urandom_range(0, 7));
					c.ack_word = pick_word();
					c.param_index_count = 16'($urandom_range(1, 8));
					set_config(c);
				end
			endcase
			target = words_sent + 120;
			while (words_sent < target) begin
				pick_pacing();
				roll = $urandom_range(0, 99);
				build_frame($urandom_range(6, 12), frame_kind_t'($urandom_range(0, 6)));
				if (roll < 60) begin
					send_frame(1'b0);
				end else if (roll < 70) begin
					send_frame(1'b1);
				end else if (roll < 78) begin
					frame_words[3] = frame_words[3] ^ nonzero16();
					send_frame(1'b0);
				end else if (roll < 86) begin
					frame_words[$urandom_range(0, 1)] ^= nonzero16();
					send_frame(1'b0);
				end else if (roll < 94) begin
					// truncated frame, last word somewhere in the header area
					n = $urandom_range(0, 7);
					while (frame_words.size() > n)
						void'(frame_words.pop_back());
					if (n == 3)
						frame_words[2] = next_seq + 16'd1;
					send_frame($urandom_range(0, 3) == 0);
				end else begin
					// noise with stray last flags, closed by a last word
					n = $urandom_range(1, 12);
					repeat (n - 1) send_word(pick_word(), $urandom_range(0, 5) == 0);
					send_word(pick_word(), 1'b1);
				end
			end
			wait_idle();
		end
	endtask

	task automatic test_overlength_frames();
		int lens[5];
		lens = '{MAX_WORDS - 1, MAX_WORDS, MAX_WORDS + 1, 63, 66};
		foreach (lens[i]) begin
			pick_pacing();
			build_frame(lens[i], ($urandom_range(0, 1) == 0) ? K_STATUS : K_ERROR);
			send_frame(1'b0);
		end
		wait_idle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_random_frames();
		test_overlength_frames();
		repeat (8) @(posedge clk);
		if (pending_verdicts.size() != 0)
			note_failure($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
		$display("sent %0d words in %0d frames across %0d register writes, %0d failures",
			words_sent, frames_sent, reg_writes, fail_count);
		$display("verdicts: ok %0d checksum %0d sequence %0d header %0d type %0d %s %0d over %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
			"payload", status_hits[5], status_hits[6]);
		if (fail_count == 0)
			$display("word_frame_response_validator_test: PASS");
		else
			$display("word_frame_response_validator_test: FAIL");
		$finish;
	end

endmodule
